// ===== src/lspd_pkg.sv =====
package lspd_pkg;

    // Packet layout: header, flags, sensor hi/lo, angle hi/lo, calib, checksum, footer.
    localparam int PKT_LEN  = 9;
    localparam int HELD_MAX = PKT_LEN - 1;
    localparam int FILL_W   = $clog2(HELD_MAX + 1);

    // Counter storage width default and the width each counter has on the result.
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int OUT_CNT_W         = 32;

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER = CFG_IDX_W'(1);

    localparam logic [7:0] HEADER_RESET = 8'hFF;
    localparam logic [7:0] FOOTER_RESET = 8'hFE;
    localparam logic [7:0] ON_LINE_MASK = 8'h01;

    // Outcome counter slots.
    localparam int CNT_GOOD  = 0;
    localparam int CNT_HDR   = 1;
    localparam int CNT_FTR   = 2;
    localparam int CNT_SUM   = 3;
    localparam int CNT_BYTES = 4;
    localparam int NUM_CNT   = 5;

    typedef enum logic [2:0] {
        STATUS_HELD     = 3'd0,
        STATUS_HDR_ERR  = 3'd1,
        STATUS_FTR_ERR  = 3'd2,
        STATUS_SUM_ERR  = 3'd3,
        STATUS_ACCEPTED = 3'd4
    } t_status;

    typedef enum logic {
        CMD_BYTE   = 1'b0,
        CMD_RESYNC = 1'b1
    } t_cmd;

    // Element 0 is the oldest held byte.
    typedef logic [HELD_MAX-1:0][7:0] t_window;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic                  data_valid;
        logic                  on_line;
        logic [15:0]           sensor_bits;
        logic signed [15:0]    angle_tenths;
        logic [7:0]            calib_state;
        logic [OUT_CNT_W-1:0]  good_packets;
        logic [OUT_CNT_W-1:0]  header_errors;
        logic [OUT_CNT_W-1:0]  footer_errors;
        logic [OUT_CNT_W-1:0]  checksum_errors;
        logic [OUT_CNT_W-1:0]  bytes_received;
    } t_out_item;

endpackage

// ===== src/lspd_frame_check.sv =====
// Checks one full candidate packet: the eight held bytes plus the arriving one.
module lspd_frame_check
    import lspd_pkg::*;
(
    input  t_window    i_window,
    input  logic [7:0] i_last_byte,
    input  logic [7:0] i_header,
    input  logic [7:0] i_footer,
    output t_status    o_status
);

    logic [7:0] sum;

    always_comb begin
        sum = 8'h00;
        for (int k = 1; k <= PKT_LEN - 3; k++) begin
            sum = sum ^ i_window[k];
        end
    end

    // Header is checked first, then footer, then the checksum.
    always_comb begin
        if (i_window[0] != i_header) begin
            o_status = STATUS_HDR_ERR;
        end else if (i_last_byte != i_footer) begin
            o_status = STATUS_FTR_ERR;
        end else if (sum != i_window[PKT_LEN-2]) begin
            o_status = STATUS_SUM_ERR;
        end else begin
            o_status = STATUS_ACCEPTED;
        end
    end

endmodule

// ===== src/line_sensor_packet_deframer_top.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each accepted item yields one result item, shown in the cycle after it is taken,
// or parked in the skid register behind a stalled result until that one leaves.
// Items can enter every cycle the skid is empty; the check is one compare/XOR stage.
// Reset is synchronous and active low; it clears the window fill, the held packet
// data, the counters and both result slots, and loads the header and footer defaults.
// The input is stalled only while the skid register holds an item.
module line_sensor_packet_deframer_top
    import lspd_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // Configuration registers.
    logic [7:0] r_header;
    logic [7:0] r_footer;

    // Deframer state. The window shifts in at the top, so the held bytes always
    // sit in the upper r_fill entries and entry 0 is the oldest once it is full.
    t_window                  r_window;
    t_window                  n_window;
    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        n_fill;
    logic                     r_held_valid;
    logic                     n_held_valid;
    logic                     r_on_line;
    logic                     n_on_line;
    logic [15:0]              r_sensor;
    logic [15:0]              n_sensor;
    logic [15:0]              r_angle;
    logic [15:0]              n_angle;
    logic [7:0]               r_calib;
    logic [7:0]               n_calib;
    logic [COUNTER_WIDTH-1:0] r_cnt [NUM_CNT];
    logic [COUNTER_WIDTH-1:0] n_cnt [NUM_CNT];

    // Result register plus skid register.
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;

    t_status   chk_status;
    t_status   status;
    t_out_item result;
    logic      in_accept;
    logic      out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_out_stall;

    lspd_frame_check u_frame_check (
        .i_window    (r_window),
        .i_last_byte (i_in_data.data_byte),
        .i_header    (r_header),
        .i_footer    (r_footer),
        .o_status    (chk_status)
    );

    // Next state for the item at the input. The check result only counts when
    // the window is already full.
    always_comb begin
        n_window     = r_window;
        n_fill       = r_fill;
        n_held_valid = r_held_valid;
        n_on_line    = r_on_line;
        n_sensor     = r_sensor;
        n_angle      = r_angle;
        n_calib      = r_calib;
        n_cnt        = r_cnt;
        status       = STATUS_HELD;

        if (i_in_data.command == CMD_RESYNC) begin
            n_fill = '0;
        end else begin
            n_cnt[CNT_BYTES] = r_cnt[CNT_BYTES] + COUNTER_WIDTH'(1);
            if (r_fill < FILL_W'(HELD_MAX)) begin
                n_window = {i_in_data.data_byte, r_window[HELD_MAX-1:1]};
                n_fill   = r_fill + FILL_W'(1);
            end else begin
                status = chk_status;
                case (chk_status)
                    STATUS_ACCEPTED: begin
                        n_cnt[CNT_GOOD] = r_cnt[CNT_GOOD] + COUNTER_WIDTH'(1);
                        n_held_valid    = 1'b1;
                        n_on_line       = |(r_window[1] & ON_LINE_MASK);
                        n_sensor        = {r_window[2], r_window[3]};
                        n_angle         = {r_window[4], r_window[5]};
                        n_calib         = r_window[6];
                        n_fill          = '0;
                    end
                    STATUS_HDR_ERR: begin
                        n_cnt[CNT_HDR] = r_cnt[CNT_HDR] + COUNTER_WIDTH'(1);
                    end
                    STATUS_FTR_ERR: begin
                        n_cnt[CNT_FTR] = r_cnt[CNT_FTR] + COUNTER_WIDTH'(1);
                    end
                    default: begin
                        n_cnt[CNT_SUM] = r_cnt[CNT_SUM] + COUNTER_WIDTH'(1);
                    end
                endcase
                // A rejected packet drops only its oldest byte.
                if (chk_status != STATUS_ACCEPTED) begin
                    n_window = {i_in_data.data_byte, r_window[HELD_MAX-1:1]};
                end
            end
        end
    end

    // The result reports the state as it stands after this item.
    always_comb begin
        result.status          = status;
        result.data_valid      = n_held_valid;
        result.on_line         = n_on_line;
        result.sensor_bits     = n_sensor;
        result.angle_tenths    = n_angle;
        result.calib_state     = n_calib;
        result.good_packets    = OUT_CNT_W'(n_cnt[CNT_GOOD]);
        result.header_errors   = OUT_CNT_W'(n_cnt[CNT_HDR]);
        result.footer_errors   = OUT_CNT_W'(n_cnt[CNT_FTR]);
        result.checksum_errors = OUT_CNT_W'(n_cnt[CNT_SUM]);
        result.bytes_received  = OUT_CNT_W'(n_cnt[CNT_BYTES]);
    end

    // Configuration writes; indexes outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_footer <= FOOTER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HEADER: r_header <= i_cfg_data;
                REG_FOOTER: r_footer <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Deframer state updates on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_held_valid <= 1'b0;
            r_on_line    <= 1'b0;
            r_sensor     <= '0;
            r_angle      <= '0;
            r_calib      <= '0;
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (in_accept) begin
            r_fill       <= n_fill;
            r_held_valid <= n_held_valid;
            r_on_line    <= n_on_line;
            r_sensor     <= n_sensor;
            r_angle      <= n_angle;
            r_calib      <= n_calib;
            r_cnt        <= n_cnt;
        end
    end

    // Window bytes carry no reset; only entries that were written are ever checked.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_window <= n_window;
        end
    end

    // Result register and skid register. The skid slot drains first so that the
    // order of results is kept; an item is only taken while the skid is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_out_valid <= 1'b1;
                r_out_data  <= result;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= result;
        end
    end

endmodule

// ===== src/lspd_sva.sv =====
module lspd_sva
    import lspd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    // The input only stalls when the result register is occupied.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    // The skid slot fills only when a held result was stalled and an item arrived.
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall && i_in_valid))
        else $error("input stall raised without a stalled result");

    // An accepted packet always leaves valid held data behind.
    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_ACCEPTED |-> o_out_data.data_valid)
        else $error("accepted packet without data_valid");

endmodule

bind line_sensor_packet_deframer_top lspd_sva u_lspd_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
